[src/erle_pkg.sv]
package erle_pkg;

    localparam int WORD_W       = 16;
    localparam int LEN_W        = 17;
    localparam int IDX_W        = 20;
    localparam int POS_BITS_DEF = 20;

    // Configuration register indexes (byte address is four times the index).
    localparam int REG_COLOUR_MODE = 0;
    localparam int PADDR_W         = 3;

    localparam logic MODE_GREY   = 1'b0;
    localparam logic MODE_COLOUR = 1'b1;

endpackage

[src/erle_grey.sv]
module erle_grey
    import erle_pkg::*;
(
    input  logic [WORD_W-1:0] i_color,
    input  logic              i_mode,
    output logic [WORD_W-1:0] o_color
);

    logic [4:0] w_red;
    logic [5:0] w_green;
    logic [4:0] w_blue;
    logic [7:0] w_sum;
    logic [5:0] w_luma;
    logic [WORD_W-1:0] w_grey;

    // The input is byte-swapped RGB565: green is split across both bytes.
    assign w_red   = i_color[7:3];
    assign w_green = {i_color[2:0], i_color[15:13]};
    assign w_blue  = i_color[12:8];
    assign w_sum   = {2'b00, w_red, 1'b0} + {2'b00, w_green} + {2'b00, w_blue, 1'b0};
    assign w_luma  = w_sum[7:2];

    // Luma goes back into all three channels of the same swapped layout.
    assign w_grey  = {w_luma[2:0], w_luma[5:1], w_luma[5:1], w_luma[5:3]};

    assign o_color = (i_mode == MODE_COLOUR) ? i_color : w_grey;

endmodule

[src/escape_rle_rgb565_decoder_unit.sv]
// Items enter the input register; results then move to the result register.
// Throughput: one item per cycle; the input register and the result register
// decouple the two channels, so the input stalls only when both are full and
// the waiting result is not being taken.
// Reset (synchronous, active low) empties both registers, sets colour_mode to 1
// and returns the parser to expecting a marker word at pixel position zero.
module escape_rle_rgb565_decoder_unit
    import erle_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF
)(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [WORD_W-1:0]  i_stream_word,
    input  logic               i_stream_start,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [WORD_W-1:0]  o_pixel_color,
    output logic [LEN_W-1:0]   o_run_length,
    output logic [IDX_W-1:0]   o_run_start_index,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [1:0] PH_MARKER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_COUNT  = 2'd2;
    localparam logic [1:0] PH_COLOUR = 2'd3;

    logic                     r_mode;
    logic                     r_in_valid;
    logic [WORD_W-1:0]        r_in_word;
    logic                     r_in_start;

    logic [1:0]               r_phase, n_phase;
    logic [WORD_W-1:0]        r_marker, n_marker;
    logic [LEN_W-1:0]         r_held_len, n_held_len;
    logic [POSITION_BITS-1:0] r_pos, n_pos;

    logic                     r_out_valid;
    logic [WORD_W-1:0]        r_out_color;
    logic [LEN_W-1:0]         r_out_len;
    logic [IDX_W-1:0]         r_out_idx;

    logic                     w_out_free;
    logic                     w_advance;
    logic                     w_in_take;
    logic                     w_emit;
    logic [WORD_W-1:0]        w_emit_raw;
    logic [WORD_W-1:0]        w_emit_color;
    logic [LEN_W-1:0]         w_emit_len;
    logic [POSITION_BITS+LEN_W-1:0] w_pos_sum;
    logic [POSITION_BITS+IDX_W-1:0] w_pos_wide;
    logic                     w_cfg_write;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;
    assign w_in_take  = i_in_valid && o_in_ready;

    assign w_cfg_write = psel && penable && pwrite && pready &&
                         (paddr[PADDR_W-1:2] == REG_COLOUR_MODE[PADDR_W-3:0]);
    assign pready = 1'b1;
    assign prdata = {31'd0, r_mode};

    always_comb begin
        n_phase    = r_phase;
        n_marker   = r_marker;
        n_held_len = r_held_len;
        w_emit     = 1'b0;
        w_emit_raw = r_in_word;
        w_emit_len = LEN_W'(1);
        if (r_in_start || r_phase == PH_MARKER) begin
            n_phase    = PH_DATA;
            n_marker   = r_in_word;
            n_held_len = '0;
        end else begin
            case (r_phase)
                PH_COUNT: begin
                    n_held_len = {1'b0, r_in_word} + LEN_W'(1);
                    n_phase    = PH_COLOUR;
                end
                PH_COLOUR: begin
                    n_phase    = PH_DATA;
                    w_emit     = 1'b1;
                    w_emit_len = r_held_len;
                end
                default: begin
                    if (r_in_word == r_marker) begin
                        n_phase = PH_COUNT;
                    end else begin
                        w_emit = 1'b1;
                    end
                end
            endcase
        end
    end

    assign w_pos_sum  = {{LEN_W{1'b0}}, r_pos} + {{POSITION_BITS{1'b0}}, w_emit_len};
    assign w_pos_wide = {{IDX_W{1'b0}}, r_pos};

    always_comb begin
        if (r_in_start || r_phase == PH_MARKER) begin
            n_pos = '0;
        end else if (w_emit) begin
            n_pos = w_pos_sum[POSITION_BITS-1:0];
        end else begin
            n_pos = r_pos;
        end
    end

    erle_grey u_grey (
        .i_color (w_emit_raw),
        .i_mode  (r_mode),
        .o_color (w_emit_color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_COLOUR;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_MARKER;
            r_marker    <= '0;
            r_held_len  <= '0;
            r_pos       <= '0;
        end else begin
            if (w_cfg_write) begin
                r_mode <= pwdata[0];
            end
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_phase    <= n_phase;
                r_marker   <= n_marker;
                r_held_len <= n_held_len;
                r_pos      <= n_pos;
            end
            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_word  <= i_stream_word;
            r_in_start <= i_stream_start;
        end
        if (w_advance && w_emit) begin
            r_out_color <= w_emit_color;
            r_out_len   <= w_emit_len;
            r_out_idx   <= w_pos_wide[IDX_W-1:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pixel_color     = r_out_color;
    assign o_run_length      = r_out_len;
    assign o_run_start_index = r_out_idx;

endmodule

[src/erle_checker.sv]
module erle_checker
    import erle_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [WORD_W-1:0] o_pixel_color,
    input logic [LEN_W-1:0]  o_run_length,
    input logic [IDX_W-1:0]  o_run_start_index,
    input logic [31:0]       prdata
);

    // The result register is empty in the cycle after a reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // A run covers 1 to 65536 pixels.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_run_length != '0) &&
                        (!o_run_length[LEN_W-1] || o_run_length[LEN_W-2:0] == '0))
        else $error("run length out of range");

    // In greyscale mode red and blue carry the same five luma bits.
    a_grey_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && prdata[0] == MODE_GREY) |->
            (o_pixel_color[12:8] == o_pixel_color[7:3]) &&
            (o_pixel_color[2:0] == o_pixel_color[7:5]))
        else $error("greyscale colour is not packed consistently");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            o_out_valid && $stable(o_pixel_color) && $stable(o_run_length) &&
            $stable(o_run_start_index))
        else $error("stalled result item changed");

endmodule

bind escape_rle_rgb565_decoder_unit erle_checker u_erle_checker (.*);
